// File: hdl/frame_heap_allocator_unit_macros.svh
// Assertion macros shared by the allocator RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef FRAME_HEAP_ALLOCATOR_UNIT_MACROS_SVH
`define FRAME_HEAP_ALLOCATOR_UNIT_MACROS_SVH

// same-cycle implication
`define FHA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("allocator check failed");

// next-cycle implication
`define FHA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("allocator check failed");

`endif

// File: hdl/fha_pkg.sv
// Types and constants for the frame heap allocator.
// No dependencies.
package fha_pkg;

	localparam logic [2:0] CMD_ALLOC  = 3'd0;
	localparam logic [2:0] CMD_FREE   = 3'd1;
	localparam logic [2:0] CMD_QUERY  = 3'd2;
	localparam logic [2:0] CMD_RECORD = 3'd3;
	localparam logic [2:0] CMD_ROLL   = 3'd4;

	localparam logic REG_BASE_ADDR  = 1'b0;
	localparam logic REG_LIMIT_ADDR = 1'b1;

	localparam logic [3:0] RECORD_ALIGN_LOG2 = 4'd2;

	typedef logic signed [35:0] addr_t;

	typedef struct packed {
		logic [31:0] tag;
		logic [31:0] head;
		logic [31:0] tail;
	} entry_t;

	typedef struct packed {
		logic push;
		logic pop;
		logic load_match;
		logic seek_shift;
		logic clr_tail;
	} stk_ctl_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ADDR,
		ST_ALIGN,
		ST_FIT,
		ST_COMMIT,
		ST_LOADM,
		ST_SEEK,
		ST_POP,
		ST_RESP
	} state_t;

endpackage

// File: hdl/fha_cell.sv
// One saved-state cell of the stack chain: tag, head and tail plus a search bit.
// Depends on fha_pkg.
module fha_cell import fha_pkg::*; #(
	parameter int IDX   = 0,
	parameter int CW    = 5
) (
	input  logic          clk,
	input  logic          arst_n,
	input  stk_ctl_t      ctl,
	input  logic [CW-1:0] cnt,
	input  logic [31:0]   seek_tag,
	input  entry_t        push_in,
	input  entry_t        pop_in,
	input  logic          match_in,
	output entry_t        ent,
	output logic          match
);

	localparam logic [CW-1:0] IDX_C = CW'(IDX);

	entry_t ent_q;
	logic   match_q;

	always_ff @(posedge clk) begin
		if (ctl.push) begin
			ent_q <= push_in;
		end else if (ctl.pop) begin
			ent_q <= pop_in;
		end else if (ctl.clr_tail) begin
			ent_q.tail <= '0;
		end
	end

	// only cells below the fill count may match
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (ctl.load_match) begin
			match_q <= (IDX_C < cnt) && ((seek_tag == '0) || (ent_q.tag == seek_tag));
		end else if (ctl.seek_shift) begin
			match_q <= match_in;
		end
	end

	assign ent   = ent_q;
	assign match = match_q;

endmodule

// File: hdl/fha_stack.sv
// Saved-state stack as a chain of cells; cell 0 holds the newest entry.
// Depends on fha_pkg and fha_cell.
module fha_stack import fha_pkg::*; #(
	parameter int DEPTH = 16,
	parameter int CW    = 5
) (
	input  logic          clk,
	input  logic          arst_n,
	input  stk_ctl_t      ctl,
	input  logic [CW-1:0] cnt,
	input  logic [31:0]   seek_tag,
	input  entry_t        new_ent,
	output entry_t        top_ent,
	output logic          top_match
);

	entry_t ent [DEPTH];
	logic   mt  [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		entry_t push_src;
		entry_t pop_src;
		logic   match_src;

		if (i == 0) begin : g_first
			assign push_src = new_ent;
		end else begin : g_mid
			assign push_src = ent[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign pop_src   = ent[i];
			assign match_src = 1'b0;
		end else begin : g_inner
			assign pop_src   = ent[i+1];
			assign match_src = mt[i+1];
		end

		fha_cell #(.IDX(i), .CW(CW)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.cnt      (cnt),
			.seek_tag (seek_tag),
			.push_in  (push_src),
			.pop_in   (pop_src),
			.match_in (match_src),
			.ent      (ent[i]),
			.match    (mt[i])
		);
	end

	assign top_ent   = ent[0];
	assign top_match = mt[0];

endmodule

// File: hdl/frame_heap_allocator_unit.sv
// Channel   Signals                       Direction
// in        in_valid / in_ready + fields  command beat into the block
// out       out_valid / out_ready + flds  one result beat per command
// cfg       APB psel/penable/pwrite       arena base at 0, arena limit at 4
//
// Allocate, query and record step through the address, align, fit and commit
// states; free goes straight to commit; a record on a full stack, a roll back on
// an empty stack or an unknown command goes straight to the response state.
// Roll back loads the match bits, then the match bit walks the cell chain one
// cell a cycle, then the chain pops one entry a cycle; with no match it ends
// after seeking through the saved states. A new command is taken only once the
// previous result is registered. No clearing pass after reset. A stalled output
// holds the finished result and the block waits in its response state.
// Depends on fha_pkg, fha_stack and frame_heap_allocator_unit_macros.svh.
`include "frame_heap_allocator_unit_macros.svh"
module frame_heap_allocator_unit import fha_pkg::*; #(
	parameter int STATE_DEPTH        = 16,
	parameter int STATE_RECORD_BYTES = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  command,
	input  logic [31:0] request_size,
	input  logic [3:0]  align_log2,
	input  logic        from_tail,
	input  logic [1:0]  free_mode,
	input  logic [31:0] state_tag,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] block_address,
	output logic        success,
	output logic [31:0] free_bytes,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int CW       = $clog2(STATE_DEPTH + 1);
	localparam int REC_SIZE = ((STATE_RECORD_BYTES + 3) / 4) * 4;
	localparam logic [CW-1:0] DEPTH_C = CW'(STATE_DEPTH);

	state_t state_q, state_d;
	stk_ctl_t ctl;

	logic [31:0] base_addr_q, limit_addr_q;
	logic [31:0] head_off_q, tail_off_q;
	logic [CW-1:0] cnt_q, j_q, rem_q;

	logic [2:0]  cmd_q;
	logic [31:0] req_q, tag_q;
	logic [3:0]  lg_q;
	logic        tail_q;
	logic [1:0]  mode_q;

	addr_t h_q, t_q, sz_q, m_q, nb_q, v_q, stop_q, nbt_q, diff_q;
	logic  vge_q;

	logic [31:0] res_addr_q, res_free_q;
	logic        res_ok_q;
	logic        out_valid_q;
	logic [31:0] out_addr_q, out_free_q;
	logic        out_ok_q;

	entry_t top_ent, new_ent;
	logic   top_match;
	logic   accept, head_fit, tail_fit, out_free;
	logic [CW-1:0] j_inc;
	logic [32:0] size0, size_r;
	logic [35:0] mask_w;

	assign accept   = in_valid && in_ready;
	assign head_fit = stop_q <= t_q;
	assign tail_fit = vge_q && (nbt_q >= h_q);
	assign out_free = !out_valid_q || out_ready;
	assign j_inc    = j_q + 1'b1;
	assign new_ent  = '{tag: tag_q, head: head_off_q, tail: tail_off_q};

	assign size0  = (req_q == '0) ? 33'd4 : {1'b0, req_q};
	assign size_r = (size0 + 33'd3) & ~33'd3;
	assign mask_w = (36'd1 << lg_q) - 36'd1;

	// configuration port
	assign pready = 1'b1;
	always_comb begin
		case (paddr[2])
			REG_BASE_ADDR:  prdata = base_addr_q;
			REG_LIMIT_ADDR: prdata = limit_addr_q;
			default:        prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_addr_q  <= '0;
			limit_addr_q <= '0;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[2])
				REG_BASE_ADDR:  base_addr_q  <= pwdata;
				REG_LIMIT_ADDR: limit_addr_q <= pwdata;
				default: ;
			endcase
		end
	end

	fha_stack #(.DEPTH(STATE_DEPTH), .CW(CW)) u_stack (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.cnt       (cnt_q),
		.seek_tag  (tag_q),
		.new_ent   (new_ent),
		.top_ent   (top_ent),
		.top_match (top_match)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (command)
						CMD_ALLOC, CMD_QUERY: state_d = ST_ADDR;
						CMD_RECORD: state_d = (cnt_q < DEPTH_C) ? ST_ADDR : ST_RESP;
						CMD_FREE:   state_d = ST_COMMIT;
						CMD_ROLL:   state_d = (cnt_q != '0) ? ST_LOADM : ST_RESP;
						default:    state_d = ST_RESP;
					endcase
				end
			end
			ST_ADDR:   state_d = ST_ALIGN;
			ST_ALIGN:  state_d = ST_FIT;
			ST_FIT:    state_d = ST_COMMIT;
			ST_COMMIT: state_d = ST_RESP;
			ST_LOADM:  state_d = ST_SEEK;
			ST_SEEK: begin
				if (top_match) begin
					state_d = ST_POP;
				end else if (j_inc == cnt_q) begin
					state_d = ST_RESP;
				end
			end
			ST_POP: begin
				if (rem_q == CW'(1)) begin
					state_d = ST_RESP;
				end
			end
			ST_RESP: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_ready = 1'b0;
		ctl      = '0;
		case (state_q)
			ST_IDLE:   in_ready = 1'b1;
			ST_COMMIT: begin
				ctl.push     = (cmd_q == CMD_RECORD) && head_fit;
				ctl.clr_tail = (cmd_q == CMD_FREE) && mode_q[1];
			end
			ST_LOADM:  ctl.load_match = 1'b1;
			ST_SEEK:   ctl.seek_shift = !top_match;
			ST_POP:    ctl.pop = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			head_off_q <= '0;
			tail_off_q <= '0;
			cnt_q      <= '0;
			j_q        <= '0;
			rem_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if ((state_q == ST_RESP) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_COMMIT: begin
					case (cmd_q)
						CMD_ALLOC: begin
							if (!tail_q && head_fit) begin
								head_off_q <= stop_q[31:0] - base_addr_q;
							end else if (tail_q && tail_fit) begin
								tail_off_q <= limit_addr_q - nbt_q[31:0];
							end
						end
						CMD_RECORD: begin
							if (head_fit) begin
								head_off_q <= stop_q[31:0] - base_addr_q;
								cnt_q      <= cnt_q + 1'b1;
							end
						end
						CMD_FREE: begin
							if (mode_q[0]) begin
								head_off_q <= '0;
								cnt_q      <= '0;
							end
							if (mode_q[1]) begin
								tail_off_q <= '0;
							end
						end
						default: ;
					endcase
				end
				ST_LOADM: j_q <= '0;
				ST_SEEK: begin
					if (top_match) begin
						rem_q <= j_inc;
					end else begin
						j_q <= j_inc;
					end
				end
				ST_POP: begin
					rem_q <= rem_q - 1'b1;
					if (rem_q == CW'(1)) begin
						head_off_q <= top_ent.head;
						tail_off_q <= top_ent.tail;
						cnt_q      <= cnt_q - j_inc;
					end
				end
				default: ;
			endcase
		end
	end

	// datapath and result staging
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					cmd_q  <= command;
					req_q  <= request_size;
					lg_q   <= (command == CMD_RECORD) ? RECORD_ALIGN_LOG2 : align_log2;
					tail_q <= from_tail;
					mode_q <= free_mode;
					tag_q  <= state_tag;
					res_addr_q <= '0;
					res_free_q <= '0;
					res_ok_q   <= 1'b0;
				end
			end
			ST_ADDR: begin
				h_q  <= $signed({4'b0, base_addr_q}) + $signed({4'b0, head_off_q});
				t_q  <= $signed({4'b0, limit_addr_q}) - $signed({4'b0, tail_off_q});
				sz_q <= (cmd_q == CMD_RECORD) ? addr_t'(REC_SIZE) : $signed({3'b0, size_r});
				m_q  <= $signed(mask_w);
			end
			ST_ALIGN: begin
				nb_q <= (h_q + m_q) & ~m_q;
				v_q  <= t_q - sz_q;
			end
			ST_FIT: begin
				stop_q <= nb_q + sz_q;
				nbt_q  <= v_q & ~m_q;
				vge_q  <= v_q >= h_q;
				diff_q <= t_q - nb_q;
			end
			ST_COMMIT: begin
				case (cmd_q)
					CMD_ALLOC: begin
						if (!tail_q && head_fit) begin
							res_addr_q <= nb_q[31:0];
							res_ok_q   <= 1'b1;
						end else if (tail_q && tail_fit) begin
							res_addr_q <= nbt_q[31:0];
							res_ok_q   <= 1'b1;
						end
					end
					CMD_RECORD: res_ok_q <= head_fit;
					CMD_QUERY: begin
						res_free_q <= (nb_q > t_q) ? '0 : diff_q[31:0];
						res_ok_q   <= 1'b1;
					end
					CMD_FREE: res_ok_q <= 1'b1;
					default: ;
				endcase
			end
			ST_POP: begin
				if (rem_q == CW'(1)) begin
					res_ok_q <= 1'b1;
				end
			end
			ST_RESP: begin
				if (out_free) begin
					out_addr_q <= res_addr_q;
					out_free_q <= res_free_q;
					out_ok_q   <= res_ok_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid     = out_valid_q;
	assign block_address = out_addr_q;
	assign success       = out_ok_q;
	assign free_bytes    = out_free_q;

	`FHA_ASSERT_IMPL(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= DEPTH_C)
	`FHA_ASSERT_IMPL(a_push_room, clk, arst_n, ctl.push, cnt_q < DEPTH_C)
	`FHA_ASSERT_IMPL(a_pop_rem, clk, arst_n, ctl.pop, (rem_q != '0) && (rem_q <= cnt_q))
	`FHA_ASSERT_NEXT(a_one_cmd, clk, arst_n, accept, !in_ready)

endmodule
